// ===== rtl/tcg_pkg.sv =====
package tcg_pkg;

   // Commands on req_command
   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Control characters
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;

   localparam int TAB_STEP    = 4;
   localparam int GLYPH_SHIFT = 3;
   localparam int CELL_W      = 32;
   localparam int QDEPTH      = 2;

   // Result kinds on rsp_kind
   localparam logic [1:0] KIND_ACK  = 2'd0;
   localparam logic [1:0] KIND_DRAW = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   // Register indexes on csr_index
   localparam logic [1:0] CSR_COLS     = 2'd0;
   localparam logic [1:0] CSR_ROWS     = 2'd1;
   localparam logic [1:0] CSR_ORIGIN_X = 2'd2;
   localparam logic [1:0] CSR_ORIGIN_Y = 2'd3;

   typedef enum logic [2:0] {
      OP_CHAR,
      OP_NEWLINE,
      OP_TAB,
      OP_BACKSPACE,
      OP_CLEAR,
      OP_READ,
      OP_NOP
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_WALK
   } back_state_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] char_code;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [5:0] cell_row;
      logic [6:0] cell_col;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_out_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

   typedef struct packed {
      logic [7:0]  cols;
      logic [6:0]  rows;
      logic [15:0] origin_x;
      logic [15:0] origin_y;
   } cfg_type;

endpackage

// ===== rtl/text_console_grid.sv =====
// Channel   Handshake                 Payload
// req       start / busy              req_command .. req_cell_col
// rsp       rsp_strobe (one cycle)    rsp_kind .. rsp_out_blue
// csr       csr_valid / csr_ready     csr_index, csr_data
//
// A put, an unknown command or a clear is answered once the back end pops it from the
// queue, through the response register; a read goes through BK_READ and the RAM read
// first. Puts follow each other one per cycle through the queue while no walk holds
// the back end. A scroll or a clear holds the back end while it walks the cell memory
// through its single write port. After reset the same clearing walk runs with busy high.
// busy also rises when the two-word queue is full; results cannot be held off.
module text_console_grid
   import tcg_pkg::*;
#(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [5:0]  req_cell_row,
   input  logic [6:0]  req_cell_col,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_pixel_x,
   output logic [15:0] rsp_pixel_y,
   output logic [7:0]  rsp_out_char,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type         cfg_ff, cfg_in;
   queue_out_type   q_out;
   back_status_type status;
   logic            pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COLS:     cfg_in.cols     = csr_data[7:0];
            CSR_ROWS:     cfg_in.rows     = csr_data[6:0];
            CSR_ORIGIN_X: cfg_in.origin_x = csr_data;
            CSR_ORIGIN_Y: cfg_in.origin_y = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cols     <= 8'd80;
         cfg_ff.rows     <= 7'd25;
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_char_code (req_char_code),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .req_cell_row  (req_cell_row),
      .req_cell_col  (req_cell_col),
      .status        (status),
      .pop           (pop),
      .q_out         (q_out)
   );

   tcg_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_out         (q_out),
      .pop           (pop),
      .status        (status),
      .rsp_strobe    (rsp_strobe),
      .rsp_kind      (rsp_kind),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_out_char  (rsp_out_char),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue)
   );

endmodule

// ===== rtl/tcg_ram.sv =====
module tcg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tcg_front.sv =====
module tcg_front
   import tcg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [1:0]      req_command,
   input  logic [7:0]      req_char_code,
   input  logic [7:0]      req_red,
   input  logic [7:0]      req_green,
   input  logic [7:0]      req_blue,
   input  logic [5:0]      req_cell_row,
   input  logic [6:0]      req_cell_col,
   input  back_status_type status,
   input  logic            pop,
   output queue_out_type   q_out
);

   localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCW = $clog2(QDEPTH + 1);

   entry_type        q_ff [QDEPTH];
   entry_type        new_entry;
   logic [QAW-1:0]   wp_ff, wp_in;
   logic [QAW-1:0]   rp_ff, rp_in;
   logic [QCW-1:0]   cnt_ff, cnt_in;
   logic             push;

   assign busy = (cnt_ff == QCW'(QDEPTH)) || status.init_busy;
   assign push = start && !busy;

   // Classify the word: control characters get their own op
   always_comb begin
      new_entry.char_code = req_char_code;
      new_entry.red       = req_red;
      new_entry.green     = req_green;
      new_entry.blue      = req_blue;
      new_entry.cell_row  = req_cell_row;
      new_entry.cell_col  = req_cell_col;
      unique case (req_command)
         CMD_PUT: begin
            unique case (req_char_code)
               CH_NEWLINE:   new_entry.op = OP_NEWLINE;
               CH_TAB:       new_entry.op = OP_TAB;
               CH_BACKSPACE: new_entry.op = OP_BACKSPACE;
               default:      new_entry.op = OP_CHAR;
            endcase
         end
         CMD_CLEAR: new_entry.op = OP_CLEAR;
         CMD_READ:  new_entry.op = OP_READ;
         default:   new_entry.op = OP_NOP;
      endcase
   end

   always_comb begin
      wp_in  = push ? QAW'(wp_ff + 1'b1) : wp_ff;
      rp_in  = pop ? QAW'(rp_ff + 1'b1) : rp_ff;
      cnt_in = QCW'(cnt_ff + QCW'(push) - QCW'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= new_entry;
      end
   end

   assign q_out.valid = (cnt_ff != '0);
   assign q_out.entry = q_ff[rp_ff];

   a_pop_has_word: assert property (@(posedge clock) disable iff (reset)
      pop |-> (cnt_ff != '0))
      else $error("queue popped while empty");

endmodule

// ===== rtl/tcg_back.sv =====
module tcg_back
   import tcg_pkg::*;
#(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  queue_out_type   q_out,
   output logic            pop,
   output back_status_type status,
   output logic            rsp_strobe,
   output logic [1:0]      rsp_kind,
   output logic [15:0]     rsp_pixel_x,
   output logic [15:0]     rsp_pixel_y,
   output logic [7:0]      rsp_out_char,
   output logic [7:0]      rsp_out_red,
   output logic [7:0]      rsp_out_green,
   output logic [7:0]      rsp_out_blue
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WW    = $clog2(DEPTH + 1);
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CXW   = $clog2(MAX_COLS + TAB_STEP);
   localparam int RXW   = $clog2(MAX_ROWS + 1);

   back_state_type state_ff, state_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [WW-1:0]  walk_ff, walk_in;
   logic [WW-1:0]  end_ff, end_in;
   logic [WW-1:0]  copy_end_ff, copy_end_in;
   logic           wb_valid_ff, wb_valid_in;
   logic [AW-1:0]  wb_addr_ff, wb_addr_in;
   logic           wb_copy_ff, wb_copy_in;
   logic           init_ff, init_in;
   logic           rd_ok_ff, rd_ok_in;

   logic           rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]     rsp_kind_ff, rsp_kind_in;
   logic [15:0]    rsp_px_ff, rsp_px_in;
   logic [15:0]    rsp_py_ff, rsp_py_in;
   logic [7:0]     rsp_char_ff, rsp_char_in;
   logic [7:0]     rsp_red_ff, rsp_red_in;
   logic [7:0]     rsp_green_ff, rsp_green_in;
   logic [7:0]     rsp_blue_ff, rsp_blue_in;

   entry_type             ent;
   logic [CXW-1:0]        nc;
   logic [RXW-1:0]        nr;
   logic [CXW-1:0]        col_x;
   logic [RXW-1:0]        row_x;
   logic                  is_put;
   logic [AW-1:0]         cursor_addr;
   logic [AW-1:0]         read_addr;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [CELL_W-1:0]     ram_wr_data;
   logic [AW-1:0]         ram_rd_addr;
   logic [CELL_W-1:0]     ram_rd_data;

   assign ent = q_out.entry;

   // Clamp the grid size into 1..MAX
   always_comb begin
      if (cfg.cols == '0) begin
         nc = CXW'(1);
      end else if ({1'b0, cfg.cols} > 9'(MAX_COLS)) begin
         nc = CXW'(MAX_COLS);
      end else begin
         nc = CXW'(cfg.cols);
      end
      if (cfg.rows == '0) begin
         nr = RXW'(1);
      end else if ({1'b0, cfg.rows} > 8'(MAX_ROWS)) begin
         nr = RXW'(MAX_ROWS);
      end else begin
         nr = RXW'(cfg.rows);
      end
   end

   assign cursor_addr = AW'(int'(row_ff) * MAX_COLS + int'(col_ff));
   assign read_addr   = AW'(int'(ent.cell_row) * MAX_COLS + int'(ent.cell_col));
   assign is_put      = (ent.op == OP_CHAR) || (ent.op == OP_NEWLINE) ||
                        (ent.op == OP_TAB) || (ent.op == OP_BACKSPACE);

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      walk_in       = walk_ff;
      end_in        = end_ff;
      copy_end_in   = copy_end_ff;
      wb_valid_in   = 1'b0;
      wb_addr_in    = wb_addr_ff;
      wb_copy_in    = wb_copy_ff;
      init_in       = init_ff;
      rd_ok_in      = rd_ok_ff;
      pop           = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cursor_addr;
      ram_wr_data   = '0;
      ram_rd_addr   = read_addr;
      col_x         = CXW'(col_ff);
      row_x         = RXW'(row_ff);
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = KIND_ACK;
      rsp_px_in     = '0;
      rsp_py_in     = '0;
      rsp_char_in   = '0;
      rsp_red_in    = '0;
      rsp_green_in  = '0;
      rsp_blue_in   = '0;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_out.valid) begin
               pop           = 1'b1;
               rsp_strobe_in = 1'b1;
               unique case (ent.op)
                  OP_CHAR: begin
                     ram_wr_en    = 1'b1;
                     ram_wr_data  = {ent.blue, ent.green, ent.red, ent.char_code};
                     rsp_kind_in  = KIND_DRAW;
                     rsp_px_in    = cfg.origin_x + 16'(int'(col_ff) << GLYPH_SHIFT);
                     rsp_py_in    = cfg.origin_y + 16'(int'(row_ff) << GLYPH_SHIFT);
                     rsp_char_in  = ent.char_code;
                     rsp_red_in   = ent.red;
                     rsp_green_in = ent.green;
                     rsp_blue_in  = ent.blue;
                     col_x        = CXW'(col_x + 1'b1);
                  end
                  OP_NEWLINE: begin
                     col_x = '0;
                     row_x = RXW'(row_x + 1'b1);
                  end
                  OP_TAB: begin
                     col_x = CXW'(col_x + CXW'(TAB_STEP));
                  end
                  OP_BACKSPACE: begin
                     ram_wr_en = 1'b1;
                     if (col_ff != '0) begin
                        col_x = CXW'(col_x - 1'b1);
                     end
                  end
                  OP_CLEAR: begin
                     col_in      = '0;
                     row_in      = '0;
                     walk_in     = '0;
                     end_in      = WW'(DEPTH);
                     copy_end_in = '0;
                     state_in    = BK_WALK;
                  end
                  OP_READ: begin
                     rsp_strobe_in = 1'b0;
                     rd_ok_in      = (int'(ent.cell_row) < MAX_ROWS) &&
                                     (int'(ent.cell_col) < MAX_COLS);
                     state_in      = BK_READ;
                  end
                  default: begin
                  end
               endcase

               if (is_put) begin
                  if (col_x >= nc) begin
                     col_x = '0;
                     row_x = RXW'(row_x + 1'b1);
                  end
                  if (row_x >= nr) begin
                     // Scroll: move rows up, then zero the bottom row
                     row_x       = RXW'(nr - 1'b1);
                     walk_in     = '0;
                     end_in      = WW'(int'(nr) * MAX_COLS);
                     copy_end_in = WW'((int'(nr) - 1) * MAX_COLS);
                     state_in    = BK_WALK;
                  end
                  col_in = CW'(col_x);
                  row_in = RW'(row_x);
               end
            end
         end

         BK_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = KIND_READ;
            if (rd_ok_ff) begin
               rsp_char_in  = ram_rd_data[7:0];
               rsp_red_in   = ram_rd_data[15:8];
               rsp_green_in = ram_rd_data[23:16];
               rsp_blue_in  = ram_rd_data[31:24];
            end
            state_in = BK_IDLE;
         end

         BK_WALK: begin
            // Each write comes in the cycle after its read, from the wb_ registers
            ram_wr_en   = wb_valid_ff;
            ram_wr_addr = wb_addr_ff;
            ram_wr_data = wb_copy_ff ? ram_rd_data : '0;
            ram_rd_addr = AW'(int'(walk_ff) + MAX_COLS);
            if (walk_ff < end_ff) begin
               wb_valid_in = 1'b1;
               wb_addr_in  = AW'(walk_ff);
               wb_copy_in  = (walk_ff < copy_end_ff);
               walk_in     = WW'(walk_ff + 1'b1);
            end else begin
               init_in  = 1'b0;
               state_in = BK_IDLE;
            end
         end

         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_WALK;
         col_ff        <= '0;
         row_ff        <= '0;
         walk_ff       <= '0;
         end_ff        <= WW'(DEPTH);
         copy_end_ff   <= '0;
         wb_valid_ff   <= 1'b0;
         init_ff       <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         walk_ff       <= walk_in;
         end_ff        <= end_in;
         copy_end_ff   <= copy_end_in;
         wb_valid_ff   <= wb_valid_in;
         init_ff       <= init_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff   <= wb_addr_in;
      wb_copy_ff   <= wb_copy_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_px_ff    <= rsp_px_in;
      rsp_py_ff    <= rsp_py_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
   end

   tcg_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign status.init_busy = init_ff;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_pixel_x      = rsp_px_ff;
   assign rsp_pixel_y      = rsp_py_ff;
   assign rsp_out_char     = rsp_char_ff;
   assign rsp_out_red      = rsp_red_ff;
   assign rsp_out_green    = rsp_green_ff;
   assign rsp_out_blue     = rsp_blue_ff;

   a_walk_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_WALK) |=> !rsp_strobe_ff)
      else $error("word issued during store walk");

   a_wb_in_walk: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> (state_ff == BK_WALK))
      else $error("walk write pending outside walk");

   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_READ) |=> (rsp_strobe_ff && (rsp_kind_ff == KIND_READ)))
      else $error("cell read gave no read word");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import tcg_pkg::*;

   localparam int GRID_COLS = 128;
   localparam int GRID_ROWS = 64;
   localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
   localparam int WALK_CYCLES = GRID_CELLS + 64;
   localparam int CYCLE_LIMIT = 64_000_000;
   localparam logic [1:0] CMD_IGNORED = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [7:0]  glyph;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } console_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_command = CMD_PUT;
   logic [7:0]  req_char_code = '0;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic [5:0]  req_cell_row = '0;
   logic [6:0]  req_cell_col = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_pixel_x;
   logic [15:0] rsp_pixel_y;
   logic [7:0]  rsp_out_char;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_COLS;
   logic [15:0] csr_data = '0;

   // shadow copy of the console: cells, cursor and registers
   logic [31:0] cell_mem [GRID_CELLS] = '{default: '0};
   int unsigned cur_col = 0;
   int unsigned cur_row = 0;
   logic [7:0]  cfg_cols = 8'd80;
   logic [6:0]  cfg_rows = 7'd25;
   logic [15:0] cfg_origin_x = '0;
   logic [15:0] cfg_origin_y = '0;

   console_rsp_type console_rsp_q[$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int word_count = 0;
   int draw_count = 0;
   int read_count = 0;
   int clear_count = 0;
   int scroll_count = 0;
   int csr_count = 0;

   text_console_grid #(.MAX_COLS(GRID_COLS), .MAX_ROWS(GRID_ROWS)) dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned grid_cols();
      if (cfg_cols == 0) return 1;
      if (cfg_cols > GRID_COLS) return GRID_COLS;
      return cfg_cols;
   endfunction

   function automatic int unsigned grid_rows();
      if (cfg_rows == 0) return 1;
      if (cfg_rows > GRID_ROWS) return GRID_ROWS;
      return cfg_rows;
   endfunction

   // Apply one word to the shadow console and return the response it causes.
   function automatic console_rsp_type console_step(logic [1:0] cmd, logic [7:0] ch,
         logic [7:0] red, logic [7:0] green, logic [7:0] blue,
         logic [5:0] row, logic [6:0] col);
      console_rsp_type rsp;
      int unsigned  n_cols;
      int unsigned  n_rows;
      int unsigned  i;
      logic [31:0]  stored;
      rsp = '0;
      rsp.kind = KIND_ACK;
      n_cols = grid_cols();
      n_rows = grid_rows();
      case (cmd)
         CMD_PUT: begin
            if (ch == CH_NEWLINE) begin
               cur_col = 0;
               cur_row++;
            end else if (ch == CH_TAB) begin
               cur_col += TAB_STEP;
            end else if (ch == CH_BACKSPACE) begin
               cell_mem[cur_row * GRID_COLS + cur_col] = '0;
               if (cur_col > 0) cur_col--;
            end else begin
               cell_mem[cur_row * GRID_COLS + cur_col] = {blue, green, red, ch};
               rsp.kind = KIND_DRAW;
               rsp.pixel_x = 16'(cfg_origin_x + (cur_col << GLYPH_SHIFT));
               rsp.pixel_y = 16'(cfg_origin_y + (cur_row << GLYPH_SHIFT));
               rsp.glyph = ch;
               rsp.red = red;
               rsp.green = green;
               rsp.blue = blue;
               draw_count++;
               cur_col++;
            end
            // recheck against the grid, which may have shrunk since the last put
            if (cur_col >= n_cols) begin
               cur_col = 0;
               cur_row++;
            end
            if (cur_row >= n_rows) begin
               // shift rows up over the full store width, blank the bottom row
               for (i = GRID_COLS; i < n_rows * GRID_COLS; i++)
                  cell_mem[i - GRID_COLS] = cell_mem[i];
               for (i = (n_rows - 1) * GRID_COLS; i < n_rows * GRID_COLS; i++)
                  cell_mem[i] = '0;
               cur_row = n_rows - 1;
               scroll_count++;
            end
         end
         CMD_CLEAR: begin
            foreach (cell_mem[k]) cell_mem[k] = '0;
            cur_col = 0;
            cur_row = 0;
            clear_count++;
         end
         CMD_READ: begin
            stored = cell_mem[row * GRID_COLS + col];
            rsp.kind = KIND_READ;
            {rsp.blue, rsp.green, rsp.red, rsp.glyph} = stored;
            read_count++;
         end
         default: begin
         end
      endcase
      return rsp;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      console_rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (console_rsp_q.size() == 0) begin
            $display("%0t: response with nothing pending, expected none, got kind %0d char %0h",
                     $time, rsp_kind, rsp_out_char);
            mismatch_count++;
         end else begin
            want = console_rsp_q.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("pixel_x", want.pixel_x, rsp_pixel_x);
            check_field("pixel_y", want.pixel_y, rsp_pixel_y);
            check_field("out_char", want.glyph, rsp_out_char);
            check_field("out_red", want.red, rsp_out_red);
            check_field("out_green", want.green, rsp_out_green);
            check_field("out_blue", want.blue, rsp_out_blue);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, console_rsp_q.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Called at a falling edge; returns at a falling edge.
   task automatic send_word(input logic [1:0] cmd, input logic [7:0] ch,
         input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue,
         input logic [5:0] row, input logic [6:0] col);
      req_command = cmd;
      req_char_code = ch;
      req_red = red;
      req_green = green;
      req_blue = blue;
      req_cell_row = row;
      req_cell_col = col;
      start = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      console_rsp_q.push_back(console_step(cmd, ch, red, green, blue, row, col));
      word_count++;
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
      csr_index = index;
      csr_data = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         CSR_COLS:     cfg_cols = data[7:0];
         CSR_ROWS:     cfg_rows = data[6:0];
         CSR_ORIGIN_X: cfg_origin_x = data;
         CSR_ORIGIN_Y: cfg_origin_y = data;
         default: begin
         end
      endcase
      csr_count++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (console_rsp_q.size() != 0) @(negedge clock);
   endtask

   // A clear or scroll keeps walking the store after its response; let it finish.
   task automatic quiesce();
      wait_drained();
      repeat (WALK_CYCLES) @(negedge clock);
   endtask

   task automatic set_grid(input logic [7:0] cols, input logic [6:0] rows,
         input logic [15:0] ox, input logic [15:0] oy);
      quiesce();
      write_reg(CSR_COLS, {8'($urandom), cols});
      write_reg(CSR_ROWS, {9'($urandom), rows});
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
   endtask

   task automatic test_reset_state();
      send_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0);
      send_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd63, 7'd127);
      send_word(CMD_PUT, 8'h41, 8'hFF, 8'h00, 8'hFF, 6'd0, 7'd0);
      // character zero is drawn and stored like any other
      send_word(CMD_PUT, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0);
      send_word(CMD_PUT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'd63, 7'd127);
      send_word(CMD_PUT, CH_BACKSPACE, 8'hFF, 8'hFF, 8'hFF, 6'd0, 7'd0);
      send_word(CMD_PUT, CH_TAB, 8'h5A, 8'hA5, 8'h3C, 6'd0, 7'd0);
      send_word(CMD_PUT, CH_NEWLINE, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0);
      // backspace at column zero stays put
      send_word(CMD_PUT, CH_BACKSPACE, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0);
      send_word(CMD_IGNORED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'd63, 7'd127);
      send_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0);
      send_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 7'd1);
      send_word(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0);
      send_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0);
   endtask

   task automatic test_register_limits();
      // zero sizes act as a single cell; origins sit at the top of the pixel range
      set_grid(8'd0, 7'd0, 16'hFFFF, 16'hFFF8);
      send_word(CMD_PUT, 8'h78, 8'h12, 8'h34, 8'h56, 6'd0, 7'd0);
      send_word(CMD_PUT, 8'h79, 8'h9A, 8'hBC, 8'hDE, 6'd0, 7'd0);
      send_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0);
      // oversize settings clamp to the full store
      set_grid(8'd255, 7'd127, 16'h1234, 16'h8000);
      send_word(CMD_PUT, 8'h5A, 8'h01, 8'h02, 8'h03, 6'd0, 7'd0);
      send_word(CMD_PUT, CH_TAB, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0);
   endtask

   task automatic test_shrunk_cursor();
      send_word(CMD_PUT, CH_NEWLINE, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0);
      send_word(CMD_PUT, CH_NEWLINE, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0);
      send_word(CMD_PUT, CH_NEWLINE, 8'h00, 8'h00, 8'h00, 6'd0, 7'd0);
      send_word(CMD_PUT, 8'h71, 8'h80, 8'h40, 8'h20, 6'd0, 7'd0);
      // cursor now sits well outside the smaller grid
      set_grid(8'd4, 7'd2, 16'($urandom), 16'($urandom));
      send_word(CMD_PUT, 8'h72, 8'h11, 8'h22, 8'h33, 6'd0, 7'd0);
      send_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd3, 7'd4);
      send_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 6'd3, 7'd5);
   endtask

   task automatic test_random_traffic(input logic [7:0] cols, input logic [6:0] rows,
         input logic [15:0] ox, input logic [15:0] oy,
         input int count, input int nl_pct, input bit idles);
      int         n;
      int         pick;
      logic [1:0] cmd;
      logic [7:0] ch;
      logic [5:0] row;
      logic [6:0] col;
      set_grid(cols, rows, ox, oy);
      for (n = 0; n < count; n++) begin
         if (idles && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 8)) @(negedge clock);
         // hold off until every response so far has come back
         if (n == count / 2) wait_drained();
         pick = $urandom_range(0, 199);
         ch = 8'($urandom);
         row = 6'($urandom);
         col = 7'($urandom);
         if (pick < 2) cmd = CMD_CLEAR;
         else if (pick < 40) cmd = CMD_READ;
         else if (pick < 44) cmd = CMD_IGNORED;
         else cmd = CMD_PUT;
         if (cmd == CMD_PUT) begin
            pick = $urandom_range(0, 99);
            if (pick < nl_pct) ch = CH_NEWLINE;
            else if (pick < nl_pct + 5) ch = CH_TAB;
            else if (pick < nl_pct + 10) ch = CH_BACKSPACE;
         end
         // aim most reads at the visible grid
         if (cmd == CMD_READ && $urandom_range(0, 9) < 7) begin
            row = 6'($urandom_range(0, grid_rows() - 1));
            col = 7'($urandom_range(0, grid_cols() - 1));
         end
         send_word(cmd, ch, 8'($urandom), 8'($urandom), 8'($urandom), row, col);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // the block clears its store after reset
      quiesce();
      test_reset_state();
      test_register_limits();
      test_shrunk_cursor();
      test_random_traffic(8'($urandom_range(1, 8)), 7'($urandom_range(1, 4)),
                          16'($urandom), 16'($urandom), 400, 10, 1'b1);
      test_random_traffic(8'd128, 7'd64, 16'($urandom), 16'($urandom), 300, 35, 1'b1);
      test_random_traffic(8'd1, 7'd1, 16'($urandom), 16'($urandom), 175, 10, 1'b1);
      test_random_traffic(8'($urandom_range(129, 255)), 7'($urandom_range(1, 3)),
                          16'hFFF0 | 16'($urandom_range(0, 15)),
                          16'hFFF0 | 16'($urandom_range(0, 15)), 300, 5, 1'b1);
      test_random_traffic(8'($urandom_range(16, 40)), 7'($urandom_range(4, 12)),
                          16'($urandom), 16'($urandom), 350, 10, 1'b1);
      // no idling for the last part
      test_random_traffic(8'($urandom_range(5, 20)), 7'($urandom_range(2, 6)),
                          16'($urandom), 16'($urandom), 350, 10, 1'b0);
      wait_drained();
      repeat (32) @(negedge clock);
      $display("%0d words: %0d glyph draws, %0d cell reads, %0d clears, %0d scrolls",
               word_count, draw_count, read_count, clear_count, scroll_count);
      $display("%0d register writes, grids from one cell to the full store, clamped sizes",
               csr_count);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
